// ===== rtl/mpwc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwc_pkg
// shared constants, register indexes and controller/datapath structs for the
// multichannel pulse width capture unit
// ----------------------------------------------------------------------------
package mpwc_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CH_W     = 2;
	localparam int COUNT_W  = 16;
	localparam int OVF_W    = 8;
	localparam int WEIGHT_W = 17;
	localparam int WIDTH_W  = 32;
	localparam int PROD_W   = WEIGHT_W + OVF_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = WEIGHT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WEIGHT    = CFG_IDX_W'(1);

	localparam logic [OVF_W-1:0]    LIMIT_RESET  = 8'hFF;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'h0FFFF;

	localparam logic MODE_CAPTURE = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	typedef struct packed {
		logic load_cap;
		logic start_tick;
		logic mul;
		logic wb;
		logic tick_step;
	} mpwc_cmd_t;

	typedef struct packed {
		logic in_range;
		logic is_tick;
		logic out_free;
		logic idx_last;
	} mpwc_sts_t;

endpackage

// ===== rtl/mpwc_cap_if.sv =====
// ----------------------------------------------------------------------------
// mpwc_cap_if
// capture event channel: valid/ready handshake with mode, channel and count
// ----------------------------------------------------------------------------
interface mpwc_cap_if;
	import mpwc_pkg::*;

	logic               valid;
	logic               ready;
	logic               mode;
	logic [CH_W-1:0]    channel;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output mode, output channel, output count, input ready);
	modport sink   (input valid, input mode, input channel, input count, output ready);

endinterface

// ===== rtl/mpwc_res_if.sv =====
// ----------------------------------------------------------------------------
// mpwc_res_if
// result channel: valid/ready handshake with channel, edge and both widths
// ----------------------------------------------------------------------------
interface mpwc_res_if;
	import mpwc_pkg::*;

	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    out_channel;
	logic               was_rising;
	logic [WIDTH_W-1:0] high_width;
	logic [WIDTH_W-1:0] low_width;

	modport source (output valid, output out_channel, output was_rising,
		output high_width, output low_width, input ready);
	modport sink   (input valid, input out_channel, input was_rising,
		input high_width, input low_width, output ready);

endinterface

// ===== rtl/multichannel_pulse_width_capture_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_pulse_width_capture_unit
// per-channel high and low pulse width measurement from timer captures
// ----------------------------------------------------------------------------
// A capture transaction steps through accept, overflow multiply and
// write-back, and one result per in-range capture leaves through a result
// register, so the next transaction is taken while that result waits; the
// write-back stalls only when the previous result has not yet been taken.
// An overflow tick is accepted and then swept across all channels, updating
// one channel record per cycle. Captures on channels at or beyond CHANNELS
// and overflow ticks produce no result.
module multichannel_pulse_width_capture_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	mpwc_cap_if.sink                        cap,
	mpwc_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [mpwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpwc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mpwc_pkg::*;

	mpwc_cmd_t cmd;
	mpwc_sts_t sts;
	logic      in_ready;

	assign cap.ready = in_ready;

	mpwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cap.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mpwc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_mode     (cap.mode),
		.in_channel  (cap.channel),
		.in_count    (cap.count),
		.cmd         (cmd),
		.sts         (sts),
		.res_valid   (res.valid),
		.res_ready   (res.ready),
		.res_channel (res.out_channel),
		.res_rising  (res.was_rising),
		.res_high    (res.high_width),
		.res_low     (res.low_width)
	);

endmodule

// ===== rtl/mpwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpwc_ctrl
// sequencer: accepts a transaction, steps a capture through multiply and
// write-back, or sweeps all channels for an overflow tick
// ----------------------------------------------------------------------------
module mpwc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mpwc_pkg::mpwc_sts_t sts,
	output mpwc_pkg::mpwc_cmd_t cmd
);
	import mpwc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_WB,
		S_TICK
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.start_tick = in_valid && sts.is_tick;
				cmd.load_cap   = in_valid && !sts.is_tick && sts.in_range;
			end
			S_MUL:  cmd.mul       = 1'b1;
			S_WB:   cmd.wb        = sts.out_free;
			S_TICK: cmd.tick_step = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start_tick) begin
						state_q <= S_TICK;
					end else if (cmd.load_cap) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (sts.idx_last) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/mpwc_dp.sv =====
// ----------------------------------------------------------------------------
// mpwc_dp
// datapath: per-channel records, configuration registers, overflow product,
// width arithmetic and the result register
// ----------------------------------------------------------------------------
module mpwc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mpwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpwc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_mode,
	input  logic [mpwc_pkg::CH_W-1:0]        in_channel,
	input  logic [mpwc_pkg::COUNT_W-1:0]     in_count,
	input  mpwc_pkg::mpwc_cmd_t              cmd,
	output mpwc_pkg::mpwc_sts_t              sts,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [mpwc_pkg::CH_W-1:0]        res_channel,
	output logic                             res_rising,
	output logic [mpwc_pkg::WIDTH_W-1:0]     res_high,
	output logic [mpwc_pkg::WIDTH_W-1:0]     res_low
);
	import mpwc_pkg::*;

	logic [OVF_W-1:0]    limit_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic                expect_fall_q [CHANNELS];
	logic [COUNT_W-1:0]  rise_q        [CHANNELS];
	logic [COUNT_W-1:0]  fall_q        [CHANNELS];
	logic [OVF_W-1:0]    ovf_q         [CHANNELS];
	logic [WIDTH_W-1:0]  high_q        [CHANNELS];
	logic [WIDTH_W-1:0]  low_q         [CHANNELS];

	logic [CH_IDX_W-1:0] idx_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0]   prod_q;

	logic                out_valid_q;
	logic [CH_W-1:0]     out_ch_q;
	logic                out_rising_q;
	logic [WIDTH_W-1:0]  out_high_q;
	logic [WIDTH_W-1:0]  out_low_q;

	logic                rising;
	logic [COUNT_W-1:0]  older;
	logic [WIDTH_W-1:0]  width;
	logic                out_free;

	assign rising   = !expect_fall_q[idx_q];
	assign older    = rising ? fall_q[idx_q] : rise_q[idx_q];
	assign width    = WIDTH_W'(prod_q) + WIDTH_W'(cnt_q) - WIDTH_W'(older);
	assign out_free = !out_valid_q || res_ready;

	assign sts.in_range = (int'(in_channel) < CHANNELS);
	assign sts.is_tick  = (in_mode == MODE_TICK);
	assign sts.out_free = out_free;
	assign sts.idx_last = (idx_q == CH_IDX_W'(CHANNELS - 1));

	assign res_valid   = out_valid_q;
	assign res_channel = out_ch_q;
	assign res_rising  = out_rising_q;
	assign res_high    = out_high_q;
	assign res_low     = out_low_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			weight_q <= WEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OVERFLOW_LIMIT: limit_q  <= cfg_data[OVF_W-1:0];
				CFG_WRAP_WEIGHT:    weight_q <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// working index, captured count and overflow product
	always_ff @(posedge clk) begin
		if (cmd.load_cap) begin
			idx_q <= CH_IDX_W'(in_channel);
			cnt_q <= in_count;
		end else if (cmd.start_tick) begin
			idx_q <= '0;
		end else if (cmd.tick_step && !sts.idx_last) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= weight_q * ovf_q[idx_q];
		end
	end

	// per-channel records
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				expect_fall_q[c] <= 1'b0;
				rise_q[c]        <= '0;
				fall_q[c]        <= '0;
				ovf_q[c]         <= '0;
				high_q[c]        <= '0;
				low_q[c]         <= '0;
			end
		end else if (cmd.wb) begin
			expect_fall_q[idx_q] <= rising;
			ovf_q[idx_q]         <= '0;
			if (rising) begin
				rise_q[idx_q] <= cnt_q;
				low_q[idx_q]  <= width;
			end else begin
				fall_q[idx_q] <= cnt_q;
				high_q[idx_q] <= width;
			end
		end else if (cmd.tick_step) begin
			if (ovf_q[idx_q] < limit_q) begin
				ovf_q[idx_q] <= ovf_q[idx_q] + 1'b1;
			end else begin
				expect_fall_q[idx_q] <= 1'b0;
				rise_q[idx_q]        <= '0;
				fall_q[idx_q]        <= '0;
				ovf_q[idx_q]         <= '0;
				high_q[idx_q]        <= '0;
				low_q[idx_q]         <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			out_ch_q     <= CH_W'(idx_q);
			out_rising_q <= rising;
			out_high_q   <= rising ? high_q[idx_q] : width;
			out_low_q    <= rising ? width : low_q[idx_q];
		end
	end

endmodule

// ===== sim/multichannel_pulse_width_capture_unit_tb.sv =====
// ----------------------------------------------------------------------------
// multichannel_pulse_width_capture_unit_tb
// Drives capture and overflow tick transactions into the pulse width capture
// unit under random source and sink stalls, predicts each channel's high and
// low widths in a scoreboard, and compares every result field by field
// across several overflow limit and wrap weight settings.
// ----------------------------------------------------------------------------
package pulse_width_tb_pkg;
	import mpwc_pkg::*;

	typedef struct {
		logic [CH_W-1:0]    ch;
		logic               rising;
		logic [WIDTH_W-1:0] high_w;
		logic [WIDTH_W-1:0] low_w;
	} width_report_t;

	class pulse_width_tracker;
		logic [OVF_W-1:0]    limit;
		logic [WEIGHT_W-1:0] weight;
		bit                  expect_fall [CHANNELS];
		logic [COUNT_W-1:0]  rise_cnt [CHANNELS];
		logic [COUNT_W-1:0]  fall_cnt [CHANNELS];
		logic [OVF_W-1:0]    ovf [CHANNELS];
		logic [WIDTH_W-1:0]  high_w [CHANNELS];
		logic [WIDTH_W-1:0]  low_w [CHANNELS];
		width_report_t       pending_widths[$];
		int                  faults;

		function new();
			limit = LIMIT_RESET;
			weight = WEIGHT_RESET;
			faults = 0;
			for (int c = 0; c < CHANNELS; c++)
				clear_channel(c);
		endfunction

		function void configure(logic [OVF_W-1:0] lim, logic [WEIGHT_W-1:0] wt);
			limit = lim;
			weight = wt;
		endfunction

		function void clear_channel(int c);
			expect_fall[c] = 0;
			rise_cnt[c] = '0;
			fall_cnt[c] = '0;
			ovf[c] = '0;
			high_w[c] = '0;
			low_w[c] = '0;
		endfunction

		function logic [WIDTH_W-1:0] span(int c, logic [COUNT_W-1:0] newer,
				logic [COUNT_W-1:0] older);
			return WIDTH_W'(weight) * WIDTH_W'(ovf[c]) + WIDTH_W'(newer) - WIDTH_W'(older);
		endfunction

		function void note_capture(logic mode, logic [CH_W-1:0] ch, logic [COUNT_W-1:0] cnt);
			width_report_t w;
			if (mode == MODE_TICK) begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (ovf[c] < limit)
						ovf[c] = ovf[c] + 1'b1;
					else
						clear_channel(c);
				end
				return;
			end
			if (int'(ch) >= CHANNELS)
				return;
			if (!expect_fall[ch]) begin
				rise_cnt[ch] = cnt;
				low_w[ch] = span(ch, cnt, fall_cnt[ch]);
				expect_fall[ch] = 1;
				w.rising = 1'b1;
			end else begin
				fall_cnt[ch] = cnt;
				high_w[ch] = span(ch, cnt, rise_cnt[ch]);
				expect_fall[ch] = 0;
				w.rising = 1'b0;
			end
			ovf[ch] = '0;
			w.ch = ch;
			w.high_w = high_w[ch];
			w.low_w = low_w[ch];
			pending_widths.push_back(w);
		endfunction

		function void note_fault(string msg);
			faults++;
			if (faults <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_widths(logic [CH_W-1:0] ch, logic rising,
				logic [WIDTH_W-1:0] hi, logic [WIDTH_W-1:0] lo);
			width_report_t want;
			if (pending_widths.size() == 0) begin
				note_fault($sformatf("unexpected result ch %0d rising %0d high %h low %h",
					ch, rising, hi, lo));
				return;
			end
			want = pending_widths.pop_front();
			if (want.ch !== ch || want.rising !== rising || want.high_w !== hi
					|| want.low_w !== lo)
				note_fault($sformatf({"ch exp %0d got %0d, rising exp %0d got %0d, ",
					"high exp %h got %h, low exp %h got %h"}, want.ch, ch,
					want.rising, rising, want.high_w, hi, want.low_w, lo));
		endfunction
	endclass

endpackage

module multichannel_pulse_width_capture_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpwc_pkg::*;
	import pulse_width_tb_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mpwc_cap_if cap ();
	mpwc_res_if res ();

	multichannel_pulse_width_capture_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap.sink),
		.res       (res.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pulse_width_tracker tracker = new();
	int results_seen = 0;
	int send_style = 0;
	int send_style_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int pick_gap(int style);
		int r;
		r = $urandom_range(0, 99);
		case (style)
			0: return 0;
			1: begin
				if (r < 50) return 0;
				else if (r < 90) return $urandom_range(1, 3);
				else return $urandom_range(4, 8);
			end
			default: begin
				if (r < 30) return 0;
				else if (r < 80) return $urandom_range(1, 4);
				else if (r < 95) return $urandom_range(5, 15);
				else return $urandom_range(20, 60);
			end
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return COUNT_W'($urandom_range(0, 15));
			3: return 16'hFFF0 | COUNT_W'($urandom_range(0, 15));
			default: return COUNT_W'($urandom);
		endcase
	endfunction

	// monitor and scoreboard hookup
	always @(posedge clk) begin
		if (arst_n) begin
			if (cap.valid && cap.ready)
				tracker.note_capture(cap.mode, cap.channel, cap.count);
			if (res.valid && res.ready) begin
				tracker.check_widths(res.out_channel, res.was_rising, res.high_width,
					res.low_width);
				results_seen <= results_seen + 1;
			end
		end
	end

	// result sink with random stalls and one long hold-off
	initial begin
		int stall_left;
		int style;
		int style_left;
		int g;
		bit held_once;
		stall_left = 0;
		style = 0;
		style_left = 0;
		held_once = 0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else if (!held_once && results_seen >= 100) begin
				held_once = 1;
				stall_left = 399;
				res.ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style = $urandom_range(0, 2);
					style_left = $urandom_range(20, 120);
				end
				style_left--;
				g = pick_gap(style);
				res.ready <= (g == 0);
				if (g > 0)
					stall_left = g - 1;
			end
		end
	end

	task automatic send_item(logic m, logic [CH_W-1:0] ch, logic [COUNT_W-1:0] cnt);
		int g;
		cap.valid <= 1'b1;
		cap.mode <= m;
		cap.channel <= ch;
		cap.count <= cnt;
		do @(posedge clk); while (!cap.ready);
		if (send_style_left == 0) begin
			send_style = $urandom_range(0, 2);
			send_style_left = $urandom_range(10, 60);
		end
		send_style_left--;
		g = pick_gap(send_style);
		if (g > 0) begin
			cap.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		cap.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_widths.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_config(logic [OVF_W-1:0] lim, logic [WEIGHT_W-1:0] wt);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OVERFLOW_LIMIT;
		cfg_data <= CFG_DATA_W'(lim);
		@(posedge clk);
		cfg_index <= CFG_WRAP_WEIGHT;
		cfg_data <= wt;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.configure(lim, wt);
		@(posedge clk);
	endtask

	initial begin
		logic [OVF_W-1:0]    limits [6];
		logic [WEIGHT_W-1:0] weights [6];
		int n;
		int k;

		limits = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd200, 8'd0};
		weights = '{17'd65535, 17'd1, 17'h1FFFF, 17'd65536, 17'd0, 17'd0};
		limits[5] = OVF_W'($urandom_range(4, 20));
		weights[5] = WEIGHT_W'($urandom_range(0, 131071));

		arst_n <= 1'b0;
		cap.valid <= 1'b0;
		cap.mode <= MODE_CAPTURE;
		cap.channel <= '0;
		cap.count <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_OVERFLOW_LIMIT;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		send_item(MODE_TICK, 2'd3, 16'hFFFF);
		send_item(MODE_CAPTURE, 2'd0, 16'h0000);
		send_item(MODE_CAPTURE, 2'd0, 16'hFFFF);
		send_item(MODE_CAPTURE, 2'd1, 16'hFFFF);
		// falling capture older than its rising partner
		send_item(MODE_CAPTURE, 2'd1, 16'h0000);
		send_item(MODE_TICK, 2'd0, 16'h0000);
		send_item(MODE_TICK, 2'd1, 16'h5555);
		send_item(MODE_CAPTURE, 2'd2, 16'h5555);
		send_item(MODE_CAPTURE, 2'd2, 16'hAAAA);
		send_item(MODE_CAPTURE, 2'd3, 16'hAAAA);
		send_item(MODE_CAPTURE, 2'd3, 16'h5555);
		send_item(MODE_CAPTURE, 2'd3, 16'h0001);
		send_item(MODE_CAPTURE, 2'd3, 16'h8000);
		send_item(MODE_TICK, 2'd2, 16'hAAAA);
		for (int c = 0; c < CHANNELS; c++)
			send_item(MODE_CAPTURE, CH_W'(c), COUNT_W'($urandom));
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			set_config(limits[p], weights[p]);
			// drive overflow counts up to the limit, then one tick past it
			repeat (limits[p]) send_item(MODE_TICK, CH_W'($urandom), COUNT_W'($urandom));
			send_item(MODE_CAPTURE, 2'd0, pick_count());
			send_item(MODE_CAPTURE, 2'd1, pick_count());
			send_item(MODE_TICK, CH_W'($urandom), COUNT_W'($urandom));
			send_item(MODE_CAPTURE, 2'd2, pick_count());
			send_item(MODE_CAPTURE, 2'd3, pick_count());
			n = 0;
			while (n < 70) begin
				if ($urandom_range(0, 99) < 15) begin
					k = $urandom_range(1, 5);
					repeat (k) send_item(MODE_TICK, CH_W'($urandom), COUNT_W'($urandom));
					n += k;
				end else begin
					send_item(MODE_CAPTURE, CH_W'($urandom_range(0, 3)), pick_count());
					n++;
				end
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending_widths.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mpwc_pkg.sv
rtl/mpwc_cap_if.sv
rtl/mpwc_res_if.sv
rtl/mpwc_ctrl.sv
rtl/mpwc_dp.sv
rtl/multichannel_pulse_width_capture_unit.sv
sim/multichannel_pulse_width_capture_unit_tb.sv
